// File: design/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

  // Field widths fixed by the item formats.
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 24;
  localparam int REM_W    = 33;
  localparam int SLOT_W   = 4;
  localparam int ALU_W    = 34;

  localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};
  // Floor of the remaining time, the most negative 33-bit value.
  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_DISPATCH = 2'd0,
    FUNC_CREATE   = 2'd1,
    FUNC_SUSPEND  = 2'd2,
    FUNC_RESUME   = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    KIND_DUE  = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_FULL = 2'd3
  } kind_e_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SATADD,
    ALU_SUBFLOOR
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP_START,
    ST_UPD_RD,
    ST_UPD_SUB,
    ST_UPD_ADD,
    ST_UPD_DUE,
    ST_MIN_RD,
    ST_MIN_CHK,
    ST_IDLE_RPT,
    ST_CREATE,
    ST_SUSP
  } state_t;

  // Request to the shared adder.
  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // Write strobes and data for the four task tables.
  typedef struct packed {
    logic                we_period;
    logic                we_rem;
    logic                we_dl;
    logic                we_comp;
    logic [PERIOD_W-1:0] period;
    logic [REM_W-1:0]    rem;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   comp;
  } tbl_wr_t;

  // Registered read data of the four task tables.
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [REM_W-1:0]    rem;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   comp;
  } tbl_rd_t;

endpackage

`default_nettype wire

// File: design/ptd_if.sv
`default_nettype none

// Request channel: one transaction is one operation on the task table.
interface ptd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic [3:0]  task_slot;
  logic [23:0] period_ms;
  logic [23:0] start_offset_ms;
  logic [23:0] suspend_delay_ms;

  modport source (
    output valid, func, now_ms, task_slot, period_ms, start_offset_ms, suspend_delay_ms,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, task_slot, period_ms, start_offset_ms, suspend_delay_ms,
    output ready
  );
endinterface

// Result channel: one transaction is one result of an operation.
interface ptd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  slot_out;
  logic        task_runs;
  logic [31:0] idle_ms;
  logic        last;

  modport source (
    output valid, result_kind, slot_out, task_runs, idle_ms, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, slot_out, task_runs, idle_ms, last,
    output ready
  );
endinterface

`default_nettype wire

// File: design/ptd_ram.sv
`default_nettype none

module ptd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/ptd_alu.sv
`default_nettype none

module ptd_alu (
  input  wire ptd_pkg::alu_req_t         req,
  output logic [ptd_pkg::ALU_W-1:0]      res
);
  import ptd_pkg::*;

  localparam logic signed [ALU_W:0] FLOOR = (ALU_W+1)'(REM_MIN);

  logic signed [ALU_W:0] ext_a;
  logic signed [ALU_W:0] ext_b;
  logic signed [ALU_W:0] sum;

  // One adder, one extra bit so that neither sums nor differences overflow.
  always_comb begin
    ext_a = $signed({req.a[ALU_W-1], req.a});
    ext_b = $signed({req.b[ALU_W-1], req.b});
    if (req.op == ALU_SUB || req.op == ALU_SUBFLOOR) begin
      sum = ext_a - ext_b;
    end else begin
      sum = ext_a + ext_b;
    end
  end

  // Saturation for time sums and the floor on the remaining time.
  always_comb begin
    case (req.op)
      ALU_SATADD: begin
        if (sum[ALU_W:TIME_W] != '0) begin
          res = ALU_W'(ALL_ONES);
        end else begin
          res = sum[ALU_W-1:0];
        end
      end
      ALU_SUBFLOOR: begin
        if (sum < FLOOR) begin
          res = FLOOR[ALU_W-1:0];
        end else begin
          res = sum[ALU_W-1:0];
        end
      end
      default: begin
        res = sum[ALU_W-1:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/ptd_seq.sv
`default_nettype none

module ptd_seq #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ptd_req_if.sink                    req,
  ptd_rsp_if.source                  rsp,
  output ptd_pkg::alu_req_t          alu_req,
  input  wire logic [ptd_pkg::ALU_W-1:0] alu_res,
  output ptd_pkg::tbl_wr_t           tbl_wr,
  output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] wr_addr,
  output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] rd_addr,
  input  wire ptd_pkg::tbl_rd_t      tbl_rd
);
  import ptd_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

  state_t               state;
  state_t               state_next;
  logic [IW-1:0]        idx;
  logic [CW-1:0]        count;
  logic [TIME_W-1:0]    last_disp;
  logic [TIME_W-1:0]    elapsed;
  func_e_t              func_r;
  logic [TIME_W-1:0]    now_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [PERIOD_W-1:0]  offset_r;
  logic [PERIOD_W-1:0]  delay_r;
  logic [REM_W-1:0]     rem_r;
  logic                 dl_zero;
  logic [TIME_W-1:0]    best;
  logic                 found;

  logic                 out_valid;
  kind_e_t              out_kind;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_runs;
  logic [TIME_W-1:0]    out_idle;
  logic                 out_last;

  logic                 out_free;
  logic                 last_idx;
  logic                 due;
  logic                 full;
  logic                 slot_ok;
  logic                 dl_expire;
  logic                 load;
  logic                 adv;

  // Status terms shared by the next-state and output logic.
  assign out_free  = !out_valid || rsp.ready;
  assign last_idx  = (CW'(idx) == count - CW'(1));
  assign due       = rem_r[REM_W-1] || (rem_r == '0);
  assign full      = (count >= CW'(MAX_TASKS));
  assign slot_ok   = (SW'(slot_r) < SW'(count));
  assign dl_expire = (tbl_rd.dl != '0) && (now_r >= tbl_rd.dl);
  assign load      = out_free && (state == ST_UPD_DUE || state == ST_IDLE_RPT ||
                                  state == ST_CREATE || state == ST_SUSP);
  assign adv       = (state == ST_UPD_ADD && !due) || (state == ST_UPD_DUE && out_free);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.slot_out    = out_slot;
  assign rsp.task_runs   = out_runs;
  assign rsp.idle_ms     = out_idle;
  assign rsp.last        = out_last;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.func)
            FUNC_DISPATCH: state_next = ST_DISP_START;
            FUNC_CREATE:   state_next = ST_CREATE;
            default:       state_next = ST_SUSP;
          endcase
        end
      end
      ST_DISP_START: state_next = (count == '0) ? ST_IDLE_RPT : ST_UPD_RD;
      ST_UPD_RD:     state_next = ST_UPD_SUB;
      ST_UPD_SUB:    state_next = ST_UPD_ADD;
      ST_UPD_ADD: begin
        if (due) begin
          state_next = ST_UPD_DUE;
        end else begin
          state_next = last_idx ? ST_MIN_RD : ST_UPD_RD;
        end
      end
      ST_UPD_DUE: begin
        if (out_free) begin
          state_next = last_idx ? ST_MIN_RD : ST_UPD_RD;
        end
      end
      ST_MIN_RD:     state_next = ST_MIN_CHK;
      ST_MIN_CHK:    state_next = last_idx ? ST_IDLE_RPT : ST_MIN_RD;
      ST_IDLE_RPT,
      ST_CREATE,
      ST_SUSP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // Adder requests and table writes for each step.
  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    tbl_wr  = '0;
    wr_addr = idx;
    rd_addr = idx;
    case (state)
      ST_DISP_START: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(now_r), b: ALU_W'(last_disp)};
      end
      ST_UPD_SUB: begin
        alu_req = '{op: ALU_SUBFLOOR, a: ALU_W'($signed(tbl_rd.rem)),
                    b: ALU_W'(elapsed)};
        tbl_wr.we_dl = dl_expire;
        tbl_wr.dl    = '0;
      end
      ST_UPD_ADD: begin
        alu_req = '{op: ALU_ADD, a: ALU_W'($signed(rem_r)), b: ALU_W'(tbl_rd.period)};
        tbl_wr.we_rem = 1'b1;
        tbl_wr.rem    = due ? alu_res[REM_W-1:0] : rem_r;
      end
      ST_UPD_DUE: begin
        alu_req = '{op: ALU_SATADD, a: ALU_W'(now_r), b: ALU_W'(tbl_rd.period)};
        tbl_wr.we_comp = out_free;
        tbl_wr.comp    = alu_res[TIME_W-1:0];
      end
      ST_IDLE_RPT: begin
        alu_req = '{op: ALU_SUB, a: ALU_W'(best), b: ALU_W'(now_r)};
      end
      ST_CREATE: begin
        alu_req = '{op: ALU_SATADD, a: ALU_W'(now_r), b: ALU_W'(offset_r)};
        wr_addr = IW'(count);
        tbl_wr.we_period = out_free && !full;
        tbl_wr.we_rem    = out_free && !full;
        tbl_wr.we_dl     = out_free && !full;
        tbl_wr.we_comp   = out_free && !full;
        tbl_wr.period    = period_r;
        tbl_wr.rem       = REM_W'(offset_r);
        tbl_wr.dl        = '0;
        tbl_wr.comp      = alu_res[TIME_W-1:0];
      end
      ST_SUSP: begin
        alu_req = '{op: ALU_SATADD, a: ALU_W'(now_r), b: ALU_W'(delay_r)};
        wr_addr = IW'(slot_r);
        tbl_wr.we_dl = out_free && slot_ok;
        tbl_wr.dl    = (func_r == FUNC_SUSPEND) ? alu_res[TIME_W-1:0] : '0;
      end
      default: begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_disp <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CREATE && out_free && !full) begin
        count <= count + CW'(1);
      end
      if (state == ST_DISP_START) begin
        last_disp <= now_r;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DISP_START) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (adv) begin
        idx <= last_idx ? '0 : idx + IW'(1);
      end else if (state == ST_MIN_CHK) begin
        idx <= idx + IW'(1);
        if (tbl_rd.comp >= now_r && (!found || tbl_rd.comp < best)) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      func_r   <= func_e_t'(req.func);
      now_r    <= req.now_ms;
      slot_r   <= req.task_slot;
      period_r <= req.period_ms;
      offset_r <= req.start_offset_ms;
      delay_r  <= req.suspend_delay_ms;
    end
    if (state == ST_DISP_START) begin
      elapsed <= alu_res[TIME_W-1:0];
    end
    if (state == ST_UPD_SUB) begin
      rem_r   <= alu_res[REM_W-1:0];
      dl_zero <= (tbl_rd.dl == '0) || dl_expire;
    end
    if (state == ST_MIN_CHK && tbl_rd.comp >= now_r && (!found || tbl_rd.comp < best)) begin
      best <= tbl_rd.comp;
    end
    if (load) begin
      out_runs <= 1'b0;
      out_idle <= '0;
      out_last <= 1'b1;
      out_slot <= '0;
      case (state)
        ST_UPD_DUE: begin
          out_kind <= KIND_DUE;
          out_slot <= SLOT_W'(idx);
          out_runs <= dl_zero;
          out_last <= 1'b0;
        end
        ST_IDLE_RPT: begin
          out_kind <= KIND_IDLE;
          out_idle <= found ? alu_res[TIME_W-1:0] : ALL_ONES;
        end
        ST_CREATE: begin
          out_kind <= full ? KIND_FULL : KIND_DONE;
          out_slot <= full ? '0 : SLOT_W'(count);
        end
        default: begin
          out_kind <= KIND_DONE;
          out_slot <= slot_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/periodic_task_dispatcher_top.sv
`default_nettype none

// Periodic task dispatcher. Holds up to MAX_TASKS periodic tasks in four
// tables (period, remaining time, resume deadline, completion time), each
// with one write port and one registered read port, and serves one request
// transaction at a time; req.ready is low while a request is worked on. A
// create, suspend or resume answers with one result. In a dispatch, one
// pass reads, updates and writes back each task (with a further step for a
// due task, which also emits its result), a second pass reads each
// completion time to find the nearest one, and the idle report closes the
// dispatch. These steps follow from the registered table read and the
// single adder that the steps share; a result that is not taken stalls the
// sequence until the output register frees up. After reset the table is
// empty and the last dispatch time is zero.
module periodic_task_dispatcher_top #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ptd_req_if.sink   req,
  ptd_rsp_if.source rsp
);
  import ptd_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;
  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;

  // Sequencer with the output register.
  ptd_seq #(.MAX_TASKS(MAX_TASKS)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .alu_req (alu_req),
    .alu_res (alu_res),
    .tbl_wr  (tbl_wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .tbl_rd  (tbl_rd)
  );

  // Shared adder.
  ptd_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Task tables.
  ptd_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_TASKS)) u_period_ram (
    .clk   (clk),
    .we    (tbl_wr.we_period),
    .waddr (wr_addr),
    .wdata (tbl_wr.period),
    .raddr (rd_addr),
    .rdata (tbl_rd.period)
  );

  ptd_ram #(.WIDTH(REM_W), .DEPTH(MAX_TASKS)) u_rem_ram (
    .clk   (clk),
    .we    (tbl_wr.we_rem),
    .waddr (wr_addr),
    .wdata (tbl_wr.rem),
    .raddr (rd_addr),
    .rdata (tbl_rd.rem)
  );

  ptd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_dl_ram (
    .clk   (clk),
    .we    (tbl_wr.we_dl),
    .waddr (wr_addr),
    .wdata (tbl_wr.dl),
    .raddr (rd_addr),
    .rdata (tbl_rd.dl)
  );

  ptd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_comp_ram (
    .clk   (clk),
    .we    (tbl_wr.we_comp),
    .waddr (wr_addr),
    .wdata (tbl_wr.comp),
    .raddr (rd_addr),
    .rdata (tbl_rd.comp)
  );

endmodule

`default_nettype wire
